>>> design/quicksort_engine_core_defines.svh
// ----------------------------------------------------------------------------
// quicksort_engine_core_defines.svh
// Assertion macros used by the quicksort engine checker.
// ----------------------------------------------------------------------------
`ifndef QUICKSORT_ENGINE_CORE_DEFINES_SVH
`define QUICKSORT_ENGINE_CORE_DEFINES_SVH

// expression must hold at every clock edge out of reset
`define QSE_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("qse: invariant violated");

// antecedent at one edge implies consequent at the next edge
`define QSE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qse: sequence check failed");

`endif

>>> design/qse_pkg.sv
// ----------------------------------------------------------------------------
// qse_pkg
// Shared types and defaults for the quicksort engine.
// ----------------------------------------------------------------------------
`default_nettype none

package qse_pkg;

	localparam int VALUE_W          = 32;
	localparam int MAX_ITEMS_DEF    = 64;
	localparam int DATA_WIDTH_DEF   = 32;

	// input word: one element, plus the mark that closes the set
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      is_last;
	} item_word_t;

	// output word: one sorted element
	typedef struct packed {
		logic signed [VALUE_W-1:0] sorted_value;
		logic                      end_of_run;
		logic                      overflowed;
	} result_word_t;

endpackage

`default_nettype wire

>>> design/qse_ram.sv
// ----------------------------------------------------------------------------
// qse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module qse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns old data on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> design/qse_sorter.sv
// ----------------------------------------------------------------------------
// qse_sorter
// Quicksort sequencer: Lomuto partition over the element RAM, pending
// ranges kept on a RAM-based stack.
// ----------------------------------------------------------------------------
`default_nettype none

module qse_sorter import qse_pkg::*; #(
	parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int AW = $clog2(MAX_ITEMS),
	localparam int CW = $clog2(MAX_ITEMS + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [CW-1:0]         count,
	output logic                       done,
	output logic                       mem_we,
	output logic      [AW-1:0]         mem_waddr,
	output logic      [DATA_WIDTH-1:0] mem_wdata,
	output logic      [AW-1:0]         mem_raddr,
	input  wire logic [DATA_WIDTH-1:0] mem_rdata
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_POP,
		S_POPW,
		S_PIV,
		S_RDJ,
		S_EVJ,
		S_SWI,
		S_SWW,
		S_FIN1,
		S_FIN2,
		S_PUSH2
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           sp_q;
	logic [AW-1:0]           lo_q, hi_q, i_q, j_q;
	logic [DATA_WIDTH-1:0]   pivot_q, aj_q;
	logic                    done_q;

	logic                    stk_we;
	logic [AW-1:0]           stk_waddr, stk_raddr;
	logic [2*AW-1:0]         stk_wdata, stk_rdata;
	logic [AW-1:0]           pop_lo, pop_hi;
	logic                    need_lo, need_hi, stk_room, take_it;
	logic [CW-1:0]           last_idx;

	assign pop_lo   = stk_rdata[2*AW-1:AW];
	assign pop_hi   = stk_rdata[AW-1:0];
	assign need_lo  = {1'b0, i_q} > ({1'b0, lo_q} + (AW+1)'(1));
	assign need_hi  = ({1'b0, i_q} + (AW+1)'(1)) < {1'b0, hi_q};
	assign stk_room = sp_q < CW'(MAX_ITEMS);
	assign take_it  = $signed(aj_q) <= $signed(pivot_q);
	assign last_idx = count - CW'(1);
	assign done     = done_q;

	qse_ram #(
		.WIDTH(2*AW),
		.DEPTH(MAX_ITEMS)
	) u_stack (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = i_q;
		mem_wdata = pivot_q;
		mem_raddr = j_q;
		stk_we    = 1'b0;
		stk_waddr = sp_q[AW-1:0];
		stk_wdata = {lo_q, hi_q};
		stk_raddr = AW'(sp_q - CW'(1));
		unique case (state_q)
			S_IDLE: begin
				stk_waddr = '0;
				stk_wdata = {AW'(0), last_idx[AW-1:0]};
				stk_we    = start && (count >= CW'(2));
			end
			S_POPW: begin
				mem_raddr = pop_hi;
			end
			S_RDJ: begin
				mem_raddr = (j_q == hi_q) ? i_q : j_q;
			end
			S_EVJ: begin
				mem_raddr = i_q;
			end
			S_SWI: begin
				mem_we    = 1'b1;
				mem_waddr = j_q;
				mem_wdata = mem_rdata;
			end
			S_SWW: begin
				mem_we    = 1'b1;
				mem_waddr = i_q;
				mem_wdata = aj_q;
			end
			S_FIN1: begin
				mem_we    = 1'b1;
				mem_waddr = hi_q;
				mem_wdata = mem_rdata;
			end
			S_FIN2: begin
				mem_we    = 1'b1;
				mem_waddr = i_q;
				mem_wdata = pivot_q;
				stk_we    = (need_lo || need_hi) && stk_room;
				stk_wdata = need_lo ? {lo_q, AW'(i_q - AW'(1))} : {AW'(i_q + AW'(1)), hi_q};
			end
			S_PUSH2: begin
				stk_we    = stk_room;
				stk_wdata = {AW'(i_q + AW'(1)), hi_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sp_q    <= '0;
			done_q  <= 1'b0;
			lo_q    <= '0;
			hi_q    <= '0;
			i_q     <= '0;
			j_q     <= '0;
			pivot_q <= '0;
			aj_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						sp_q    <= (count >= CW'(2)) ? CW'(1) : CW'(0);
						state_q <= S_POP;
					end
				end
				S_POP: begin
					if (sp_q == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						sp_q    <= sp_q - CW'(1);
						state_q <= S_POPW;
					end
				end
				S_POPW: begin
					lo_q    <= pop_lo;
					hi_q    <= pop_hi;
					i_q     <= pop_lo;
					j_q     <= pop_lo;
					state_q <= (pop_lo >= pop_hi) ? S_POP : S_PIV;
				end
				S_PIV: begin
					pivot_q <= mem_rdata;
					state_q <= S_RDJ;
				end
				S_RDJ: begin
					state_q <= (j_q == hi_q) ? S_FIN1 : S_EVJ;
				end
				S_EVJ: begin
					aj_q <= mem_rdata;
					if ($signed(mem_rdata) <= $signed(pivot_q)) begin
						if (i_q == j_q) begin
							i_q     <= i_q + AW'(1);
							j_q     <= j_q + AW'(1);
							state_q <= S_RDJ;
						end else begin
							state_q <= S_SWI;
						end
					end else begin
						j_q     <= j_q + AW'(1);
						state_q <= S_RDJ;
					end
				end
				S_SWI: begin
					state_q <= S_SWW;
				end
				S_SWW: begin
					i_q     <= i_q + AW'(1);
					j_q     <= j_q + AW'(1);
					state_q <= S_RDJ;
				end
				S_FIN1: begin
					state_q <= S_FIN2;
				end
				S_FIN2: begin
					if ((need_lo || need_hi) && stk_room) begin
						sp_q <= sp_q + CW'(1);
					end
					state_q <= (need_lo && need_hi) ? S_PUSH2 : S_POP;
				end
				S_PUSH2: begin
					if (stk_room) begin
						sp_q <= sp_q + CW'(1);
					end
					state_q <= S_POP;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// aj_q is also the compare operand held for the swap write
			if (state_q == S_SWI && !take_it) begin
				aj_q <= aj_q;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/quicksort_engine_core.sv
// ----------------------------------------------------------------------------
// quicksort_engine_core
// Load, quicksort in place, and stream out a set of signed elements.
// ----------------------------------------------------------------------------
// Words arrive on the item channel one per cycle and are written straight
// into the element RAM; a word whose is_last bit is set closes the set and
// starts the sort. Up to MAX_ITEMS elements are kept; later words of the same
// set are dropped and every result of that run carries overflowed = 1 (a
// dropped last word still starts the sort). The sort is quicksort with a
// Lomuto partition on the last element of each range, with pending ranges
// on a small RAM stack. All sort traffic goes through the single read and
// single write port of the element RAM. Each range starts with a stack pop,
// a stack read and a pivot read; each scanned element is read and compared,
// and a swap adds two RAM writes; the pivot is placed by a read and two
// writes, then one more stack write when both sides go back on the stack.
// The item channel is held off from the last word until the final result
// has been taken. Results then stream out in ascending order, one read at
// a time as a RAM read and then an output register load, waiting while the
// output is held; the largest carries end_of_run. Then a new set is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module quicksort_engine_core import qse_pkg::*; #(
	parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         item_valid,
	output logic              item_ready,
	input  wire item_word_t   item,
	output logic              result_valid,
	input  wire logic         result_ready,
	output result_word_t      result
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	typedef enum logic [1:0] {
		T_LOAD,
		T_SORT,
		T_EMIT
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         count_q;      // elements held
	logic                  ovf_q;        // a word of this set was dropped
	logic                  start_q;      // one-cycle kick to the sorter
	logic [CW-1:0]         k_q;          // next element to read out
	logic                  rd_s1;        // readout RAM read in flight
	logic                  last_s1;      // ... and it is the largest element
	logic                  result_valid_q;
	result_word_t          result_q;

	logic                  item_fire, result_fire, emit_issue, has_room;
	logic                  sort_done;

	// element RAM port, shared between loader, sorter and readout
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

	// sorter side of the RAM port
	logic                  srt_we;
	logic [AW-1:0]         srt_waddr, srt_raddr;
	logic [DATA_WIDTH-1:0] srt_wdata;

	assign item_ready   = (state_q == T_LOAD);
	assign item_fire    = item_valid && item_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign result_fire  = result_valid_q && result_ready;
	assign has_room     = count_q < CW'(MAX_ITEMS);

	// read the next element only when the output register will be free
	assign emit_issue = (state_q == T_EMIT) && !rd_s1 && (k_q < count_q)
		&& (!result_valid_q || result_fire);

	qse_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(MAX_ITEMS)
	) u_elements (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	qse_sorter #(
		.MAX_ITEMS (MAX_ITEMS),
		.DATA_WIDTH(DATA_WIDTH)
	) u_sorter (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.count    (count_q),
		.done     (sort_done),
		.mem_we   (srt_we),
		.mem_waddr(srt_waddr),
		.mem_wdata(srt_wdata),
		.mem_raddr(srt_raddr),
		.mem_rdata(ram_rdata)
	);

	// RAM port ownership follows the phase
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = DATA_WIDTH'($unsigned(item.value));
		ram_raddr = k_q[AW-1:0];
		unique case (state_q)
			T_LOAD: begin
				ram_we = item_fire && has_room;
			end
			T_SORT: begin
				ram_we    = srt_we;
				ram_waddr = srt_waddr;
				ram_wdata = srt_wdata;
				ram_raddr = srt_raddr;
			end
			T_EMIT: begin
				ram_raddr = k_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= T_LOAD;
			count_q        <= '0;
			ovf_q          <= 1'b0;
			start_q        <= 1'b0;
			k_q            <= '0;
			rd_s1          <= 1'b0;
			last_s1        <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			start_q <= 1'b0;
			rd_s1   <= emit_issue;
			unique case (state_q)
				T_LOAD: begin
					if (item_fire) begin
						if (has_room) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (item.is_last) begin
							start_q <= 1'b1;
							state_q <= T_SORT;
						end
					end
				end
				T_SORT: begin
					if (sort_done) begin
						k_q     <= '0;
						state_q <= T_EMIT;
					end
				end
				T_EMIT: begin
					if (emit_issue) begin
						k_q     <= k_q + CW'(1);
						last_s1 <= (k_q + CW'(1)) == count_q;
					end
					// final word taken: start a new set
					if (result_fire && result_q.end_of_run) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= T_LOAD;
					end
				end
				default: begin
					state_q <= T_LOAD;
				end
			endcase
			// output register: load wins, otherwise drain on accept
			if (rd_s1) begin
				result_valid_q        <= 1'b1;
				result_q.sorted_value <= VALUE_W'(ram_rdata);
				result_q.end_of_run   <= last_s1;
				result_q.overflowed   <= ovf_q;
			end else if (result_fire) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/qse_checker.sv
// ----------------------------------------------------------------------------
// qse_checker
// Port-level checks for the quicksort engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quicksort_engine_core_defines.svh"

module qse_checker import qse_pkg::*; (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         item_valid,
	input wire logic         item_ready,
	input wire item_word_t   item,
	input wire logic         result_valid,
	input wire logic         result_ready,
	input wire result_word_t result
);

	// a stalled result word holds
	`QSE_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

	// loading and readout never overlap
	`QSE_ASSERT_ALWAYS(a_phase_excl, !(item_ready && result_valid))

	// a word without the last mark keeps the engine loading
	`QSE_ASSERT_NEXT(a_keep_loading, item_valid && item_ready && !item.is_last, item_ready)

	// the final word of a run hands the engine back to loading
	`QSE_ASSERT_NEXT(a_run_close, result_valid && result_ready && result.end_of_run, item_ready && !result_valid)

endmodule

bind quicksort_engine_core qse_checker u_qse_checker (.*);

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for quicksort_engine_core.
// ----------------------------------------------------------------------------
// Sets of signed words go in on the item channel, and each set is closed by a
// word with is_last set. The bench keeps its own copy of the element store.
// When a set closes it sorts that copy with the same in-place quicksort (a
// Lomuto partition on the last element, pending ranges on an explicit stack)
// and queues the ascending sequence as the expected output. Each word taken on
// the result channel is checked field by field against the oldest expected
// word. The stimulus is a handful of hand-picked sets (a single element,
// extremes, duplicates, sorted and reversed runs) followed by random sets.
// Most random sets are small. One fills the store exactly, and one overruns
// it so that the closing word is dropped. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	import qse_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int MAX_ITEMS   = MAX_ITEMS_DEF;
	localparam int RING        = 256;     // far more than one run can have in flight
	localparam int ITEM_TARGET = 330;
	localparam int STALL_LIMIT = 60000;   // idle cycles
	localparam int TAIL_CYCLES = 50;

	localparam logic signed [VALUE_W-1:0] MAX_V = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] MIN_V = {1'b1, {(VALUE_W-1){1'b0}}};

	// one pending input word, with the idle cycles to spend before it and an
	// option to hold it back until every expected result has been drained
	typedef struct {
		item_word_t word;
		int         gap;
		bit         drain;
	} feed_entry_t;

	logic         clk          = 1'b0;
	logic         arst_n       = 1'b0;
	logic         item_valid   = 1'b0;
	logic         item_ready;
	item_word_t   item         = '0;
	logic         result_valid;
	logic         result_ready = 1'b0;
	result_word_t result;

	feed_entry_t  feed_q[$];
	int           n_items = 0;
	int           gap_cnt;

	// bench copy of the engine state for the set being loaded
	logic signed [VALUE_W-1:0] set_buf [MAX_ITEMS];
	int           set_count   = 0;
	bit           set_dropped = 1'b0;

	// expected results: written at ring_head by the driver, consumed at
	// ring_tail by the monitor; both counters move only by nonblocking updates
	result_word_t sorted_ring [RING];
	int           ring_head;
	int           ring_tail;

	int           stall_cnt;
	int           calm_left;
	int           idle_cycles;
	int           errors = 0;

	quicksort_engine_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// In-place quicksort of set_buf[0 .. n-1]. Every range on the stack holds
	// at least two elements, so the stack never goes past n/2 entries.
	task automatic quicksort_set(input int n);
		int lo_stack [MAX_ITEMS];
		int hi_stack [MAX_ITEMS];
		int depth;
		int lo;
		int hi;
		int i;
		int j;
		logic signed [VALUE_W-1:0] pivot;
		logic signed [VALUE_W-1:0] tmp;
		depth = 0;
		if (n >= 2) begin
			lo_stack[0] = 0;
			hi_stack[0] = n - 1;
			depth = 1;
		end
		while (depth > 0) begin
			depth--;
			lo = lo_stack[depth];
			hi = hi_stack[depth];
			pivot = set_buf[hi];
			i = lo;
			for (j = lo; j < hi; j++) begin
				if (set_buf[j] <= pivot) begin
					tmp = set_buf[i];
					set_buf[i] = set_buf[j];
					set_buf[j] = tmp;
					i++;
				end
			end
			// pivot goes into place only after the scan
			tmp = set_buf[i];
			set_buf[i] = set_buf[hi];
			set_buf[hi] = tmp;
			if (i > lo + 1) begin
				lo_stack[depth] = lo;
				hi_stack[depth] = i - 1;
				depth++;
			end
			if (i + 1 < hi) begin
				lo_stack[depth] = i + 1;
				hi_stack[depth] = hi;
				depth++;
			end
		end
	endtask

	// Take one accepted input word into the bench model. A closing word sorts
	// the set and queues one expected result per stored element.
	task automatic absorb_word(input item_word_t w);
		int k;
		result_word_t r;
		if (set_count < MAX_ITEMS) begin
			set_buf[set_count] = w.value;
			set_count++;
		end else begin
			set_dropped = 1'b1;     // store full: word dropped, run is flagged
		end
		if (w.is_last) begin
			quicksort_set(set_count);
			for (k = 0; k < set_count; k++) begin
				r.sorted_value = set_buf[k];
				r.end_of_run   = (k == set_count - 1);
				r.overflowed   = set_dropped;
				sorted_ring[(ring_head + k) % RING] <= r;
			end
			ring_head <= ring_head + set_count;
			set_count = 0;
			set_dropped = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus construction
	// ------------------------------------------------------------------------

	function automatic logic signed [VALUE_W-1:0] pick_value(input int flavor);
		if (flavor <= 5)
			return $urandom;                        // full range
		if (flavor <= 8)
			return int'($urandom_range(0, 8)) - 4;  // tight cluster, lots of ties
		case ($urandom_range(0, 5))
			0:       return MAX_V;
			1:       return MIN_V;
			2:       return MAX_V - 1;
			3:       return MIN_V + 1;
			4:       return -1;
			default: return 0;
		endcase
	endfunction

	task automatic push_word(input logic signed [VALUE_W-1:0] v, input bit last,
			input int gap, input bit drain);
		feed_entry_t e;
		e.word.value   = v;
		e.word.is_last = last;
		e.gap          = gap;
		e.drain        = drain;
		feed_q.push_back(e);
		n_items++;
	endtask

	// Random set of n words: either a monotonic run (the quicksort worst case)
	// or independent values. Some sets go with no sender gaps at all.
	task automatic add_set(input int n, input bit drain);
		int k;
		int shape;
		int step;
		bit calm;
		logic signed [VALUE_W-1:0] v;
		shape = $urandom_range(0, 5);
		step  = $urandom_range(0, 3);
		calm  = ($urandom_range(0, 3) == 0);
		v     = pick_value($urandom_range(0, 9));
		for (k = 0; k < n; k++) begin
			if (shape == 0)
				v = v + step;
			else if (shape == 1)
				v = v - step;
			else
				v = pick_value($urandom_range(0, 9));
			push_word(v, k == n - 1, calm ? 0 : $urandom_range(0, 6), drain && k == 0);
		end
	endtask

	// ------------------------------------------------------------------------
	// Driver: feeds item words from feed_q and updates the model on acceptance
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drive_items
		logic accepted;
		logic settled;
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
			gap_cnt    <= 0;
			ring_head  <= 0;
		end else begin
			accepted = item_valid && item_ready;
			if (accepted)
				absorb_word(item);
			// all results in; a set closing right now does not count as settled
			settled = (ring_tail == ring_head) && !(accepted && item.is_last);
			if (!item_valid || accepted) begin
				if (feed_q.size() == 0 || (feed_q[0].drain && !settled)) begin
					item_valid <= 1'b0;
				end else if (gap_cnt < feed_q[0].gap) begin
					item_valid <= 1'b0;
					gap_cnt    <= gap_cnt + 1;
				end else begin
					item       <= feed_q[0].word;
					item_valid <= 1'b1;
					gap_cnt    <= 0;
					void'(feed_q.pop_front());
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: random back-pressure and in-order check of result words
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : watch_results
		result_word_t want;
		int pause;
		if (!arst_n) begin
			result_ready <= 1'b0;
			stall_cnt    <= 0;
			calm_left    <= 0;
			ring_tail    <= 0;
		end else if (result_valid && result_ready) begin
			if (ring_tail == ring_head) begin
				$error("unexpected result word: sorted_value %0d", result.sorted_value);
				errors++;
			end else begin
				want = sorted_ring[ring_tail % RING];
				if (result.sorted_value !== want.sorted_value) begin
					$error("sorted_value: expected %0d, got %0d",
						want.sorted_value, result.sorted_value);
					errors++;
				end
				if (result.end_of_run !== want.end_of_run) begin
					$error("end_of_run: expected %0b, got %0b",
						want.end_of_run, result.end_of_run);
					errors++;
				end
				if (result.overflowed !== want.overflowed) begin
					$error("overflowed: expected %0b, got %0b",
						want.overflowed, result.overflowed);
					errors++;
				end
				ring_tail <= ring_tail + 1;
			end
			// stall before the next word; now and then a long stretch with none
			if (calm_left > 0) begin
				calm_left <= calm_left - 1;
				pause = 0;
			end else begin
				pause = $urandom_range(0, 6);
				if ($urandom_range(0, 15) == 0)
					calm_left <= $urandom_range(8, 40);
			end
			stall_cnt    <= pause;
			result_ready <= (pause == 0);
		end else if (stall_cnt > 0) begin
			stall_cnt    <= stall_cnt - 1;
			result_ready <= (stall_cnt == 1);
		end else begin
			result_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: too long with no word moving on either channel
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("FAIL quicksort_engine_core");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		bit big_done;
		bit over_done;
		big_done    = 1'b0;
		over_done   = 1'b0;
		idle_cycles = 0;

		// single-element set
		push_word(MAX_V, 1'b1, $urandom_range(0, 6), 1'b0);
		// two elements, reversed
		push_word(MAX_V, 1'b0, $urandom_range(0, 6), 1'b0);
		push_word(MIN_V, 1'b1, $urandom_range(0, 6), 1'b0);
		// extremes mixed with a repeated value
		push_word(0,         1'b0, $urandom_range(0, 6), 1'b0);
		push_word(-1,        1'b0, $urandom_range(0, 6), 1'b0);
		push_word(1,         1'b0, $urandom_range(0, 6), 1'b0);
		push_word(MAX_V,     1'b0, $urandom_range(0, 6), 1'b0);
		push_word(MIN_V,     1'b0, $urandom_range(0, 6), 1'b0);
		push_word(MAX_V - 1, 1'b0, $urandom_range(0, 6), 1'b0);
		push_word(MIN_V + 1, 1'b0, $urandom_range(0, 6), 1'b0);
		push_word(-1,        1'b0, $urandom_range(0, 6), 1'b0);
		push_word(0,         1'b1, $urandom_range(0, 6), 1'b0);
		// already ascending
		push_word(-3, 1'b0, 0, 1'b0);
		push_word(-2, 1'b0, 0, 1'b0);
		push_word(-1, 1'b0, 0, 1'b0);
		push_word(0,  1'b0, 0, 1'b0);
		push_word(1,  1'b1, 0, 1'b0);
		// all equal; the sender holds off until the previous run has drained
		push_word(7, 1'b0, 0, 1'b1);
		push_word(7, 1'b0, 0, 1'b0);
		push_word(7, 1'b0, 0, 1'b0);
		push_word(7, 1'b1, 0, 1'b0);
		// descending
		push_word(5, 1'b0, $urandom_range(0, 6), 1'b0);
		push_word(4, 1'b0, $urandom_range(0, 6), 1'b0);
		push_word(3, 1'b1, $urandom_range(0, 6), 1'b0);

		// random sets; one fills the store exactly, one overruns it so the
		// closing word itself is dropped
		while (n_items < ITEM_TARGET) begin
			if (!big_done && n_items > 120) begin
				add_set(MAX_ITEMS, 1'b0);
				big_done = 1'b1;
			end else if (!over_done && n_items > 220) begin
				add_set(MAX_ITEMS + 2, 1'b0);
				over_done = 1'b1;
			end else begin
				add_set($urandom_range(1, 16), $urandom_range(0, 5) == 0);
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		wait (feed_q.size() == 0);
		@(posedge clk);
		wait (!item_valid);
		@(posedge clk);
		wait (ring_tail == ring_head);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("PASS quicksort_engine_core");
		else
			$display("FAIL quicksort_engine_core");
		$finish;
	end

endmodule
